// ----- hdl/lhkt_pkg.sv -----
// Shared constants, codes and control types of the hot key tracker.
package lhkt_pkg;

   localparam int TABLE_SLOTS_DEF = 64;
   localparam int KEY_BITS_DEF    = 64;
   localparam int CNT_W           = 32;
   localparam int TIME_W          = 32;
   localparam int CFG_W           = 7;
   localparam int CSR_W           = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int OP_W            = 3;
   localparam int MAX_RESULTS     = 64;

   // operation codes
   localparam logic [OP_W-1:0] OP_TOUCH = 3'd0;
   localparam logic [OP_W-1:0] OP_INCR  = 3'd1;
   localparam logic [OP_W-1:0] OP_SET   = 3'd2;
   localparam logic [OP_W-1:0] OP_ATTEN = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMING  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE      = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_DECIDE,
      ST_GAP,
      ST_COMMIT,
      ST_AT_HALVE,
      ST_AT_LOADV,
      ST_AT_CMP,
      ST_AT_PUT,
      ST_AT_COPY,
      ST_RD_INIT,
      ST_RD_SCAN,
      ST_RD_EMIT
   } lhkt_state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_FIND,
      ACT_DECIDE,
      ACT_GAP,
      ACT_COMMIT,
      ACT_HALVE,
      ACT_LOADV,
      ACT_CMP,
      ACT_PUT,
      ACT_COPY,
      ACT_RD_INIT,
      ACT_RD_SCAN,
      ACT_RD_EMIT
   } lhkt_act_type;

   typedef struct packed {
      lhkt_act_type act;
      logic         issue;
   } lhkt_cmd_type;

   typedef struct packed {
      logic dec_gap;
      logic dec_write;
      logic occ_zero;
      logic rd_last;
   } lhkt_sts_type;

endpackage

// ----- hdl/lhkt_ctrl.sv -----
// Sequencer of the hot key tracker: state machine, scan counter and slot pointer.
module lhkt_ctrl #(
   parameter int TABLE_SLOTS = lhkt_pkg::TABLE_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lhkt_pkg::OP_W-1:0]        req_op,
   input  lhkt_pkg::lhkt_sts_type           sts,
   output logic                             busy,
   output lhkt_pkg::lhkt_cmd_type           cmd,
   output logic [$clog2(TABLE_SLOTS)-1:0]   cmd_addr
);
   import lhkt_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam logic [IW:0]   SCAN_END  = (IW+1)'(TABLE_SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

   lhkt_state_type state_ff, state_in;
   logic [IW:0]    idx_ff, idx_in;
   logic [IW-1:0]  v_ff, v_in;
   logic           scan_done;
   logic           scanning;

   assign scan_done = (idx_ff == SCAN_END);

   // next state and counters
   always_comb begin
      state_in = state_ff;
      idx_in   = '0;
      v_in     = v_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_op)
                  OP_TOUCH, OP_INCR, OP_SET: state_in = ST_FIND;
                  OP_ATTEN:                  state_in = ST_AT_HALVE;
                  OP_READ:                   state_in = ST_RD_INIT;
                  default:                   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIND: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.dec_gap)        state_in = ST_GAP;
            else if (sts.dec_write) state_in = ST_COMMIT;
            else                    state_in = ST_IDLE;
         end
         ST_GAP: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: state_in = ST_IDLE;
         ST_AT_HALVE: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) begin
               state_in = ST_AT_LOADV;
               v_in     = '0;
            end
         end
         ST_AT_LOADV: state_in = ST_AT_CMP;
         ST_AT_CMP: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) state_in = ST_AT_PUT;
         end
         ST_AT_PUT: begin
            v_in     = v_ff + 1'b1;
            state_in = (v_ff == LAST_SLOT) ? ST_AT_COPY : ST_AT_LOADV;
         end
         ST_AT_COPY: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) state_in = ST_IDLE;
         end
         ST_RD_INIT: state_in = sts.occ_zero ? ST_RD_EMIT : ST_RD_SCAN;
         ST_RD_SCAN: begin
            idx_in = scan_done ? '0 : idx_ff + 1'b1;
            if (scan_done) state_in = ST_RD_EMIT;
         end
         ST_RD_EMIT: state_in = sts.rd_last ? ST_IDLE : ST_RD_SCAN;
         default:    state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.act  = ACT_NONE;
      scanning = 1'b0;
      unique case (state_ff)
         ST_IDLE:     cmd.act = start ? ACT_LOAD : ACT_NONE;
         ST_FIND:     begin cmd.act = ACT_FIND;    scanning = 1'b1; end
         ST_DECIDE:   cmd.act = ACT_DECIDE;
         ST_GAP:      begin cmd.act = ACT_GAP;     scanning = 1'b1; end
         ST_COMMIT:   cmd.act = ACT_COMMIT;
         ST_AT_HALVE: begin cmd.act = ACT_HALVE;   scanning = 1'b1; end
         ST_AT_LOADV: cmd.act = ACT_LOADV;
         ST_AT_CMP:   begin cmd.act = ACT_CMP;     scanning = 1'b1; end
         ST_AT_PUT:   cmd.act = ACT_PUT;
         ST_AT_COPY:  begin cmd.act = ACT_COPY;    scanning = 1'b1; end
         ST_RD_INIT:  cmd.act = ACT_RD_INIT;
         ST_RD_SCAN:  begin cmd.act = ACT_RD_SCAN; scanning = 1'b1; end
         ST_RD_EMIT:  cmd.act = ACT_RD_EMIT;
         default:     cmd.act = ACT_NONE;
      endcase
      cmd.issue = scanning && !scan_done;
      cmd_addr  = (state_ff == ST_AT_LOADV || state_ff == ST_AT_PUT) ? v_ff : idx_ff[IW-1:0];
      busy      = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         v_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         v_ff     <= v_in;
      end
   end

endmodule

// ----- hdl/lhkt_dp.sv -----
// Datapath of the hot key tracker: slot memories, valid bits, scan accumulators, result register.
module lhkt_dp #(
   parameter int TABLE_SLOTS = lhkt_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BITS    = lhkt_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lhkt_pkg::lhkt_cmd_type            cmd,
   input  logic [$clog2(TABLE_SLOTS)-1:0]    cmd_addr,
   output lhkt_pkg::lhkt_sts_type            sts,
   input  logic [lhkt_pkg::OP_W-1:0]         req_op,
   input  logic [KEY_BITS-1:0]               req_key,
   input  logic [lhkt_pkg::CNT_W-1:0]        req_amount,
   input  logic [lhkt_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                              csr_we,
   input  logic [lhkt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lhkt_pkg::CSR_W-1:0]        csr_wdata,
   output logic                              rsp_valid,
   output logic [KEY_BITS-1:0]               rsp_out_key,
   output logic [lhkt_pkg::CNT_W-1:0]        rsp_out_count,
   output logic                              rsp_has_entry,
   output logic                              rsp_last
);
   import lhkt_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int OW = IW + 1;
   localparam int LW = (OW + 1 > CFG_W + 1) ? OW + 1 : CFG_W + 1;
   localparam logic [LW-1:0] SLOTS_L = LW'(TABLE_SLOTS);
   localparam logic [LW-1:0] MAXR_L  = LW'(MAX_RESULTS);

   // slot memories
   logic [KEY_BITS-1:0] key_mem   [TABLE_SLOTS];
   logic [CNT_W-1:0]    cnt_mem   [TABLE_SLOTS];
   logic [CNT_W-1:0]    old_mem   [TABLE_SLOTS];
   logic [TIME_W-1:0]   time_mem  [TABLE_SLOTS];
   logic [IW-1:0]       rank_mem  [TABLE_SLOTS];
   logic [IW-1:0]       nrank_mem [TABLE_SLOTS];

   logic [KEY_BITS-1:0] rd_key_ff;
   logic [CNT_W-1:0]    rd_cnt_ff, rd_old_ff;
   logic [TIME_W-1:0]   rd_time_ff;
   logic [IW-1:0]       rd_rank_ff, rd_nrank_ff;

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [OW-1:0]          occ_ff, occ_new_ff;

   // config
   logic [CFG_W-1:0]  cap_ff, warm_ff;
   logic [TIME_W-1:0] age_ff;

   // latched item
   logic [OP_W-1:0]     op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    amount_ff;
   logic [TIME_W-1:0]   now_ff;

   // read pipeline
   lhkt_act_type  p_act_ff;
   logic          p_vld_ff;
   logic [IW-1:0] p_addr_ff;
   logic          pv;

   // find accumulators
   logic          hit_ff, free_ok_ff, min_ok_ff;
   logic [IW-1:0] hit_idx_ff, hit_rank_ff, free_idx_ff, min_idx_ff, min_rank_ff;
   logic [CNT_W-1:0] hit_cnt_ff, min_cnt_ff;

   // update plan
   logic          cm_set_ff;
   logic [IW-1:0] cm_idx_ff, cm_rank_ff, gap_rank_ff, skip_ff;
   logic [CNT_W-1:0] cm_cnt_ff;

   // attenuate
   logic [CNT_W-1:0] vc_ff, vo_ff;
   logic [IW-1:0]    vr_ff, cntr_ff;

   // read
   logic [CFG_W-1:0]    want_ff, k_ff;
   logic                bounded_ff, best_ok_ff;
   logic [CNT_W-1:0]    bc_ff, best_c_ff;
   logic [IW-1:0]       br_ff, best_r_ff;
   logic [KEY_BITS-1:0] best_key_ff;

   logic                rsp_vld_ff, rsp_has_ff, rsp_last_ff;
   logic [KEY_BITS-1:0] rsp_key_ff;
   logic [CNT_W-1:0]    rsp_cnt_ff;

   // decision logic
   logic [CNT_W-1:0] addend, upd_cnt, new_cnt;
   logic [CNT_W:0]   sum;
   logic [LW-1:0]    lim_sum, limit, occ_l, cap1, want_a, want_b;
   logic             full, aged, upd_zero;

   always_comb begin
      addend   = (op_ff == OP_TOUCH) ? CNT_W'(1) : amount_ff;
      sum      = {1'b0, hit_cnt_ff} + {1'b0, addend};
      upd_cnt  = (op_ff == OP_SET) ? amount_ff : (sum[CNT_W] ? '1 : sum[CNT_W-1:0]);
      upd_zero = (upd_cnt == '0);
      new_cnt  = (op_ff == OP_TOUCH) ? CNT_W'(1) : amount_ff;
      lim_sum  = LW'(cap_ff) + LW'(warm_ff);
      limit    = (lim_sum > SLOTS_L) ? SLOTS_L : lim_sum;
      occ_l    = LW'(occ_ff);
      full     = (occ_l >= limit) && (occ_ff != '0);
      cap1     = (cap_ff == '0) ? LW'(1) : LW'(cap_ff);
      want_a   = (cap1 > occ_l) ? occ_l : cap1;
      want_b   = (want_a > MAXR_L) ? MAXR_L : want_a;
      aged     = (now_ff - rd_time_ff) >= age_ff;
      pv       = p_vld_ff && valid_ff[p_addr_ff];

      sts.dec_gap   = hit_ff || ((new_cnt != '0) && full);
      sts.dec_write = hit_ff ? !upd_zero : (new_cnt != '0);
      sts.occ_zero  = (occ_ff == '0);
      sts.rd_last   = (occ_ff == '0) || ((k_ff + 1'b1) == want_ff);
   end

   // memory read ports
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[cmd_addr];
      rd_cnt_ff   <= cnt_mem[cmd_addr];
      rd_old_ff   <= old_mem[cmd_addr];
      rd_time_ff  <= time_mem[cmd_addr];
      rd_rank_ff  <= rank_mem[cmd_addr];
      rd_nrank_ff <= nrank_mem[cmd_addr];
   end

   // memory write ports
   always_ff @(posedge clock) begin
      if (cmd.act == ACT_COMMIT && cm_set_ff) begin
         key_mem[cm_idx_ff]  <= key_ff;
         cnt_mem[cm_idx_ff]  <= cm_cnt_ff;
         time_mem[cm_idx_ff] <= now_ff;
      end else if (p_act_ff == ACT_HALVE && pv) begin
         cnt_mem[p_addr_ff] <= aged ? (rd_cnt_ff >> 1) : rd_cnt_ff;
         old_mem[p_addr_ff] <= rd_cnt_ff;
         if (aged) time_mem[p_addr_ff] <= now_ff;
      end
      priority if (cmd.act == ACT_COMMIT && cm_set_ff) begin
         rank_mem[cm_idx_ff] <= cm_rank_ff;
      end else if (p_act_ff == ACT_GAP && pv && p_addr_ff != skip_ff
                   && rd_rank_ff > gap_rank_ff) begin
         rank_mem[p_addr_ff] <= rd_rank_ff - 1'b1;
      end else if (p_act_ff == ACT_COPY && p_vld_ff) begin
         rank_mem[p_addr_ff] <= rd_nrank_ff;
      end
      if (cmd.act == ACT_PUT && valid_ff[cmd_addr] && vc_ff != '0)
         nrank_mem[cmd_addr] <= cntr_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         occ_ff     <= '0;
         occ_new_ff <= '0;
         cap_ff     <= CFG_W'(32);
         warm_ff    <= CFG_W'(32);
         age_ff     <= '0;
         p_act_ff   <= ACT_NONE;
         p_vld_ff   <= 1'b0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
         min_ok_ff  <= 1'b0;
         cm_set_ff  <= 1'b0;
         bounded_ff <= 1'b0;
         best_ok_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         p_act_ff   <= cmd.act;
         p_vld_ff   <= cmd.issue;
         rsp_vld_ff <= (cmd.act == ACT_RD_EMIT);
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAPACITY: cap_ff  <= csr_wdata[CFG_W-1:0];
               CSR_WARMING:  warm_ff <= csr_wdata[CFG_W-1:0];
               CSR_AGE:      age_ff  <= csr_wdata[TIME_W-1:0];
               default:      ;
            endcase
         end
         if (cmd.act == ACT_LOAD) begin
            hit_ff     <= 1'b0;
            free_ok_ff <= 1'b0;
            min_ok_ff  <= 1'b0;
            occ_new_ff <= '0;
         end
         if (p_act_ff == ACT_FIND && p_vld_ff) begin
            if (pv && rd_key_ff == key_ff) hit_ff <= 1'b1;
            if (!valid_ff[p_addr_ff]) free_ok_ff <= 1'b1;
            if (pv) min_ok_ff <= 1'b1;
         end
         if (cmd.act == ACT_DECIDE) begin
            if (hit_ff) begin
               cm_set_ff <= !upd_zero;
               if (upd_zero) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  occ_ff <= occ_ff - 1'b1;
               end
            end else if (new_cnt != '0) begin
               cm_set_ff <= 1'b1;
               if (full) valid_ff[min_idx_ff] <= 1'b0;
               else      occ_ff <= occ_ff + 1'b1;
            end else begin
               cm_set_ff <= 1'b0;
            end
         end
         if (cmd.act == ACT_COMMIT && cm_set_ff) valid_ff[cm_idx_ff] <= 1'b1;
         if (cmd.act == ACT_PUT) begin
            if (valid_ff[cmd_addr] && vc_ff == '0) begin
               valid_ff[cmd_addr] <= 1'b0;
               occ_ff <= occ_new_ff;
            end else if (valid_ff[cmd_addr]) begin
               occ_new_ff <= occ_new_ff + 1'b1;
               occ_ff     <= occ_new_ff + 1'b1;
            end else begin
               occ_ff <= occ_new_ff;
            end
         end
         if (cmd.act == ACT_RD_INIT) begin
            bounded_ff <= 1'b0;
            best_ok_ff <= 1'b0;
         end
         if (p_act_ff == ACT_RD_SCAN && pv
             && (!bounded_ff || {rd_cnt_ff, rd_rank_ff} < {bc_ff, br_ff})
             && (!best_ok_ff || {best_c_ff, best_r_ff} < {rd_cnt_ff, rd_rank_ff}))
            best_ok_ff <= 1'b1;
         if (cmd.act == ACT_RD_EMIT) begin
            bounded_ff <= 1'b1;
            best_ok_ff <= 1'b0;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      p_addr_ff <= cmd_addr;
      if (cmd.act == ACT_LOAD) begin
         op_ff     <= req_op;
         key_ff    <= req_key;
         amount_ff <= req_amount;
         now_ff    <= req_now_ms;
      end
      if (p_act_ff == ACT_FIND && pv) begin
         if (rd_key_ff == key_ff) begin
            hit_idx_ff  <= p_addr_ff;
            hit_cnt_ff  <= rd_cnt_ff;
            hit_rank_ff <= rd_rank_ff;
         end
         if (!min_ok_ff || {rd_cnt_ff, rd_rank_ff} < {min_cnt_ff, min_rank_ff}) begin
            min_idx_ff  <= p_addr_ff;
            min_cnt_ff  <= rd_cnt_ff;
            min_rank_ff <= rd_rank_ff;
         end
      end
      if (p_act_ff == ACT_FIND && p_vld_ff && !valid_ff[p_addr_ff] && !free_ok_ff)
         free_idx_ff <= p_addr_ff;
      if (cmd.act == ACT_DECIDE) begin
         if (hit_ff) begin
            gap_rank_ff <= hit_rank_ff;
            skip_ff     <= hit_idx_ff;
            cm_idx_ff   <= hit_idx_ff;
            cm_cnt_ff   <= upd_cnt;
            cm_rank_ff  <= IW'(occ_ff - 1'b1);
         end else begin
            cm_cnt_ff <= new_cnt;
            if (full) begin
               gap_rank_ff <= min_rank_ff;
               skip_ff     <= min_idx_ff;
               cm_idx_ff   <= (!free_ok_ff || min_idx_ff < free_idx_ff) ? min_idx_ff
                                                                        : free_idx_ff;
               cm_rank_ff  <= IW'(occ_ff - 1'b1);
            end else begin
               cm_idx_ff  <= free_idx_ff;
               cm_rank_ff <= IW'(occ_ff);
            end
         end
      end
      if (p_act_ff == ACT_LOADV) begin
         vc_ff   <= rd_cnt_ff;
         vo_ff   <= rd_old_ff;
         vr_ff   <= rd_rank_ff;
         cntr_ff <= '0;
      end
      if (p_act_ff == ACT_CMP && pv && rd_cnt_ff != '0
          && {rd_cnt_ff, rd_old_ff, rd_rank_ff} < {vc_ff, vo_ff, vr_ff})
         cntr_ff <= cntr_ff + 1'b1;
      if (cmd.act == ACT_RD_INIT) begin
         want_ff <= want_b[CFG_W-1:0];
         k_ff    <= '0;
      end
      if (p_act_ff == ACT_RD_SCAN && pv
          && (!bounded_ff || {rd_cnt_ff, rd_rank_ff} < {bc_ff, br_ff})
          && (!best_ok_ff || {best_c_ff, best_r_ff} < {rd_cnt_ff, rd_rank_ff})) begin
         best_key_ff <= rd_key_ff;
         best_c_ff   <= rd_cnt_ff;
         best_r_ff   <= rd_rank_ff;
      end
      if (cmd.act == ACT_RD_EMIT) begin
         k_ff        <= k_ff + 1'b1;
         bc_ff       <= best_c_ff;
         br_ff       <= best_r_ff;
         rsp_key_ff  <= sts.occ_zero ? '0 : best_key_ff;
         rsp_cnt_ff  <= sts.occ_zero ? '0 : best_c_ff;
         rsp_has_ff  <= !sts.occ_zero;
         rsp_last_ff <= sts.rd_last;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_count = rsp_cnt_ff;
   assign rsp_has_entry = rsp_has_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- hdl/lfu_hot_key_tracker.sv -----
// Top level of the LFU hot key tracker: sequencer plus datapath, with interface checks.
//
// Usage: drive req_op, req_key, req_amount and req_now_ms with start high; the
// command is taken at the clock edge where start is high and busy is low.
// Ops: touch, increment, set (update one key, evict the coldest entry when the
// table is at its limit), attenuate (halve aged entries, reorder) and read.
// Only a read produces results: each result sits on the rsp_ ports for one
// cycle with rsp_valid high; rsp_last marks the final transfer of the run.
// The receiver cannot stall; every strobe is taken.
// Registers are written through csr_we/csr_index/csr_wdata; the user must do so while busy is low (not enforced).
// Each op runs as memory scans of N = TABLE_SLOTS slots, one slot per cycle:
//   touch/increment/set: a match scan, then a rank repair scan only when
//   needed and a commit only when something is written.
//   attenuate: a halving scan, then each slot's new rank is counted against all
//   slots in one scan, then the new ranks are copied in a final scan.
//   read: one scan per result; an empty read answers without a scan.
// Reset clears valid bits, occupancy and registers (capacity 32, warming 32,
// age limit 0) at once; no clearing pass is needed.
module lfu_hot_key_tracker #(
   parameter int TABLE_SLOTS = lhkt_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BITS    = lhkt_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lhkt_pkg::OP_W-1:0]         req_op,
   input  logic [KEY_BITS-1:0]               req_key,
   input  logic [lhkt_pkg::CNT_W-1:0]        req_amount,
   input  logic [lhkt_pkg::TIME_W-1:0]       req_now_ms,
   output logic                              rsp_valid,
   output logic [KEY_BITS-1:0]               rsp_out_key,
   output logic [lhkt_pkg::CNT_W-1:0]        rsp_out_count,
   output logic                              rsp_has_entry,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [lhkt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lhkt_pkg::CSR_W-1:0]        csr_wdata
);
   import lhkt_pkg::*;

   lhkt_cmd_type                   cmd;
   lhkt_sts_type                   sts;
   logic [$clog2(TABLE_SLOTS)-1:0] cmd_addr;

   // sequence the scans
   lhkt_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_op   (req_op),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd),
      .cmd_addr (cmd_addr)
   );

   // hold the table and build each transfer
   lhkt_dp #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cmd_addr      (cmd_addr),
      .sts           (sts),
      .req_op        (req_op),
      .req_key       (req_key),
      .req_amount    (req_amount),
      .req_now_ms    (req_now_ms),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_count (rsp_out_count),
      .rsp_has_entry (rsp_has_entry),
      .rsp_last      (rsp_last)
   );

   // a result is only ever built while a command is in progress
   a_rsp_in_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe outside a command");

   // an empty-table answer is always the last of its run
   a_empty_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_entry |-> rsp_last)
      else $error("empty result not marked last");

   // attenuate and read always take the sequencer out of idle
   a_long_ops_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_ATTEN || req_op == OP_READ) |=> busy)
      else $error("accepted command did not start");

   // nothing may be shown once a run has finished and the block is idle again
   a_no_stray_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result after last transfer");

endmodule
